@@ design/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg - shared definitions for the LRU cache tag store
// Sizes, access and register codes, command struct and small helpers.
// ----------------------------------------------------------------------------
package salc_pkg;

	localparam int MAX_SETS  = 64;
	localparam int MAX_WAYS  = 8;
	localparam int ADDR_BITS = 64;

	localparam int SET_W     = $clog2(MAX_SETS);
	localparam int WAY_W     = $clog2(MAX_WAYS);
	localparam int WAYCNT_W  = 4;
	localparam int RANK_W    = WAY_W;
	localparam int TOTAL_W   = 32;
	localparam int KIND_W    = 2;
	localparam int HITS_W    = 2;
	localparam int SBITS_W   = 3;
	localparam int BBITS_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 5;

	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

	localparam logic [KIND_W-1:0] KIND_IFETCH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STORE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

	typedef logic [ADDR_BITS-1:0] tag_t;
	typedef logic [RANK_W-1:0]    rank_t;

	typedef struct packed {
		logic clear;   // reset pass, zero one valid row
		logic capture; // item taken, start the set read
		logic commit;  // lookup done, write back and load result
	} salc_cmd_t;

	// set bit count clamped to what fits the set array
	function automatic logic [SBITS_W-1:0] eff_set_bits(input logic [SBITS_W-1:0] s);
		if (s > SBITS_W'(SET_W))
			return SBITS_W'(SET_W);
		return s;
	endfunction

	function automatic logic [WAYCNT_W-1:0] eff_ways(input logic [WAYCNT_W-1:0] w);
		if (w == '0)
			return WAYCNT_W'(1);
		if (w > WAYCNT_W'(MAX_WAYS))
			return WAYCNT_W'(MAX_WAYS);
		return w;
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
			input logic [HITS_W-1:0] b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + (TOTAL_W+1)'(b);
		if (s[TOTAL_W])
			return '1;
		return s[TOTAL_W-1:0];
	endfunction

endpackage

@@ design/salc_access_if.sv @@
// ----------------------------------------------------------------------------
// salc_access_if - access channel
// One memory access per item: kind and byte address.
// ----------------------------------------------------------------------------
interface salc_access_if;
	logic                              valid;
	logic                              ready;
	logic [salc_pkg::KIND_W-1:0]       access_kind;
	logic [salc_pkg::ADDR_BITS-1:0]    address;

	modport source (output valid, output access_kind, output address, input ready);
	modport sink   (input valid, input access_kind, input address, output ready);
endinterface

@@ design/salc_result_if.sv @@
// ----------------------------------------------------------------------------
// salc_result_if - result channel
// Per-access hit/miss/eviction flags and running totals.
// ----------------------------------------------------------------------------
interface salc_result_if;
	logic                            valid;
	logic                            ready;
	logic [salc_pkg::HITS_W-1:0]     hit_count;
	logic                            was_miss;
	logic                            was_eviction;
	logic [salc_pkg::TOTAL_W-1:0]    total_hits;
	logic [salc_pkg::TOTAL_W-1:0]    total_misses;
	logic [salc_pkg::TOTAL_W-1:0]    total_evictions;

	modport source (output valid, output hit_count, output was_miss, output was_eviction,
		output total_hits, output total_misses, output total_evictions, input ready);
	modport sink   (input valid, input hit_count, input was_miss, input was_eviction,
		input total_hits, input total_misses, input total_evictions, output ready);
endinterface

@@ design/salc_ctrl.sv @@
// ----------------------------------------------------------------------------
// salc_ctrl - sequencing controller
// Three-state FSM: clear the valid rows after reset, then per item take it
// and read its set, then look up and write back. Owns the result valid flag.
// ----------------------------------------------------------------------------
module salc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  clr_last,
	output salc_pkg::salc_cmd_t   cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.clear   = (state_q == ST_CLEAR);
	assign cmd.capture = in_valid && in_ready;
	// result register frees up in the same cycle it is drained
	assign cmd.commit  = (state_q == ST_LOOK) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd.capture)
						state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (cmd.commit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ design/salc_dp.sv @@
// ----------------------------------------------------------------------------
// salc_dp - tag store datapath
// Config registers, address split, tag/rank/valid row memories with a
// clearing pass after reset, parallel tag compare, LRU victim pick, rank
// update and saturating totals.
// ----------------------------------------------------------------------------
module salc_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  salc_pkg::salc_cmd_t                    cmd,
	output logic                                   clr_last,
	input  logic                                   cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [salc_pkg::CFG_DAT_W-1:0]         cfg_data,
	input  logic [salc_pkg::KIND_W-1:0]            in_kind,
	input  logic [salc_pkg::ADDR_BITS-1:0]         in_address,
	output logic [salc_pkg::HITS_W-1:0]            hit_count,
	output logic                                   was_miss,
	output logic                                   was_eviction,
	output logic [salc_pkg::TOTAL_W-1:0]           total_hits,
	output logic [salc_pkg::TOTAL_W-1:0]           total_misses,
	output logic [salc_pkg::TOTAL_W-1:0]           total_evictions
);

	localparam int NW = salc_pkg::MAX_WAYS;

	// configuration
	logic [salc_pkg::SBITS_W-1:0]  set_bits_q;
	logic [salc_pkg::BBITS_W-1:0]  block_bits_q;
	logic [salc_pkg::WAYCNT_W-1:0] ways_q;

	// captured access
	logic [salc_pkg::KIND_W-1:0]   kind_q;
	salc_pkg::tag_t                tag_q;
	logic [salc_pkg::SET_W-1:0]    set_q;

	// row memories and their registered read data
	salc_pkg::tag_t [NW-1:0]       tag_mem [salc_pkg::MAX_SETS];
	salc_pkg::rank_t [NW-1:0]      rank_mem [salc_pkg::MAX_SETS];
	logic [NW-1:0]                 valid_mem [salc_pkg::MAX_SETS];
	salc_pkg::tag_t [NW-1:0]       tag_row_q;
	salc_pkg::rank_t [NW-1:0]      rank_row_q;
	logic [NW-1:0]                 valid_row_q;

	// clearing pass position
	logic [salc_pkg::SET_W-1:0]    clr_set_q;

	// totals and result payload
	logic [salc_pkg::TOTAL_W-1:0]  hit_tot_q, miss_tot_q, evict_tot_q;
	logic [salc_pkg::HITS_W-1:0]   hit_count_q;
	logic                          was_miss_q, was_evict_q;

	// address split
	logic [salc_pkg::ADDR_BITS-1:0] shifted;
	logic [salc_pkg::SBITS_W-1:0]   s_eff;
	logic [salc_pkg::SET_W-1:0]     set_mask;
	logic [salc_pkg::SET_W-1:0]     rd_set;
	salc_pkg::tag_t                 rd_tag;

	always_comb begin
		shifted  = in_address >> block_bits_q;
		s_eff    = salc_pkg::eff_set_bits(set_bits_q);
		set_mask = salc_pkg::SET_W'(((salc_pkg::SET_W+1)'(1) << s_eff)
			- (salc_pkg::SET_W+1)'(1));
		rd_set   = shifted[salc_pkg::SET_W-1:0] & set_mask;
		rd_tag   = shifted >> s_eff;
	end

	// lookup
	logic [salc_pkg::WAYCNT_W-1:0] ways;
	logic [NW-1:0]                 valid_row, in_use, match, free;
	salc_pkg::rank_t [NW-1:0]      rk, rk_new;
	logic                          hit, has_free, is_access, miss, evict, wr_en;
	logic [salc_pkg::WAY_W-1:0]    hit_way, free_way, vic_way, way;
	salc_pkg::rank_t               vic_rank;
	logic [salc_pkg::RANK_W:0]     limit;
	logic [NW-1:0]                 valid_new;
	salc_pkg::tag_t [NW-1:0]       tag_new;
	logic [salc_pkg::HITS_W-1:0]   hits;
	logic                          vwr_en;
	logic [salc_pkg::SET_W-1:0]    vwr_set;
	logic [NW-1:0]                 vwr_data;

	always_comb begin
		ways      = salc_pkg::eff_ways(ways_q);
		valid_row = valid_row_q;
		for (int i = 0; i < NW; i++) begin
			in_use[i] = salc_pkg::WAYCNT_W'(i) < ways;
			// invalid lines always rank as newest
			rk[i]     = valid_row[i] ? rank_row_q[i] : '0;
			match[i]  = in_use[i] && valid_row[i] && (tag_row_q[i] == tag_q);
			free[i]   = in_use[i] && !valid_row[i];
		end
		hit      = |match;
		has_free = |free;

		hit_way  = '0;
		free_way = '0;
		for (int i = NW - 1; i >= 0; i--) begin
			if (match[i])
				hit_way = salc_pkg::WAY_W'(i);
			if (free[i])
				free_way = salc_pkg::WAY_W'(i);
		end

		// oldest way, lowest index on ties
		vic_way  = '0;
		vic_rank = rk[0];
		for (int i = 1; i < NW; i++) begin
			if (in_use[i] && rk[i] > vic_rank) begin
				vic_way  = salc_pkg::WAY_W'(i);
				vic_rank = rk[i];
			end
		end

		priority if (hit) begin
			way   = hit_way;
			limit = {1'b0, rk[hit_way]};
		end else if (has_free) begin
			way   = free_way;
			limit = (salc_pkg::RANK_W+1)'(NW);
		end else begin
			way   = vic_way;
			limit = {1'b0, vic_rank};
		end

		for (int i = 0; i < NW; i++) begin
			if (salc_pkg::WAY_W'(i) == way)
				rk_new[i] = '0;
			else if (in_use[i] && valid_row[i] && ({1'b0, rk[i]} < limit)
					&& (rk[i] < salc_pkg::RANK_MAX))
				rk_new[i] = rk[i] + salc_pkg::RANK_W'(1);
			else
				rk_new[i] = rk[i];
		end

		valid_new = valid_row;
		tag_new   = tag_row_q;
		if (!hit) begin
			valid_new = valid_row | (NW'(1) << way);
			tag_new[way] = tag_q;
		end

		is_access = (kind_q != salc_pkg::KIND_IFETCH);
		miss      = is_access && !hit;
		evict     = is_access && !hit && !has_free;
		hits      = '0;
		if (is_access)
			hits = salc_pkg::HITS_W'(hit)
				+ salc_pkg::HITS_W'(kind_q == salc_pkg::KIND_MODIFY);
		wr_en     = cmd.commit && is_access;

		// one valid write port, shared by the clearing pass and write-back
		vwr_en   = cmd.clear || wr_en;
		vwr_set  = cmd.clear ? clr_set_q : set_q;
		vwr_data = cmd.clear ? '0 : valid_new;
	end

	// row memories: read on capture, write on commit; never in the same cycle
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_row_q   <= tag_mem[rd_set];
			rank_row_q  <= rank_mem[rd_set];
			valid_row_q <= valid_mem[rd_set];
		end
		if (wr_en) begin
			tag_mem[set_q]  <= tag_new;
			rank_mem[set_q] <= rk_new;
		end
		if (vwr_en)
			valid_mem[vwr_set] <= vwr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			tag_q  <= rd_tag;
			set_q  <= rd_set;
		end
		if (cmd.commit) begin
			hit_count_q <= hits;
			was_miss_q  <= miss;
			was_evict_q <= evict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_q       <= salc_pkg::WAYCNT_W'(1);
			hit_tot_q    <= '0;
			miss_tot_q   <= '0;
			evict_tot_q  <= '0;
			clr_set_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					salc_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_data[salc_pkg::SBITS_W-1:0];
					salc_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data[salc_pkg::BBITS_W-1:0];
					salc_pkg::CFG_WAYS:       ways_q       <= cfg_data[salc_pkg::WAYCNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear)
				clr_set_q <= clr_set_q + salc_pkg::SET_W'(1);
			if (cmd.commit) begin
				hit_tot_q   <= salc_pkg::sat_add(hit_tot_q, hits);
				miss_tot_q  <= salc_pkg::sat_add(miss_tot_q, salc_pkg::HITS_W'(miss));
				evict_tot_q <= salc_pkg::sat_add(evict_tot_q, salc_pkg::HITS_W'(evict));
			end
		end
	end

	assign clr_last        = (clr_set_q == salc_pkg::SET_W'(salc_pkg::MAX_SETS - 1));
	assign hit_count       = hit_count_q;
	assign was_miss        = was_miss_q;
	assign was_eviction    = was_evict_q;
	assign total_hits      = hit_tot_q;
	assign total_misses    = miss_tot_q;
	assign total_evictions = evict_tot_q;

endmodule

@@ design/set_assoc_lru_cache_sim.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim - set-associative cache tag store, LRU replacement
// Counts hits, misses and evictions for a stream of memory accesses.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        content
//  access    in   valid/ready      access_kind, address
//  result    out  valid/ready      hit_count, was_miss, was_eviction, totals
//  cfg       in   cfg_we           cfg_index, cfg_data (write only)
//
//  Per item, the capture step reads the set's tag, rank and valid rows
//  from the row memories, and the lookup step compares all ways, picks the LRU victim
//  and writes the row back while loading the result register.
//  A result held by a stalled consumer holds the lookup step; a new item is
//  taken while the previous result waits. Reset clears totals and config registers
//  at once; a clearing pass then zeroes one valid row a cycle, all 64 rows,
//  before the first item is taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [salc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [salc_pkg::CFG_DAT_W-1:0]     cfg_data,
	salc_access_if.sink                        access,
	salc_result_if.source                      result
);

	salc_pkg::salc_cmd_t cmd;
	logic                clr_last;

	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (access.valid),
		.in_ready  (access.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.clr_last  (clr_last),
		.cmd       (cmd)
	);

	salc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.clr_last        (clr_last),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_kind         (access.access_kind),
		.in_address      (access.address),
		.hit_count       (result.hit_count),
		.was_miss        (result.was_miss),
		.was_eviction    (result.was_eviction),
		.total_hits      (result.total_hits),
		.total_misses    (result.total_misses),
		.total_evictions (result.total_evictions)
	);

endmodule

@@ bench/set_assoc_lru_cache_sim_tb.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_tb - self-checking bench for the LRU cache tag store
// Drives memory accesses through several cache geometries and idling
// patterns. A behavioural tag store predicts each result, and every result
// is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_tb;
	import salc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LINE_COUNT  = MAX_SETS * MAX_WAYS;
	localparam int BURST_LEN   = 160;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [ADDR_BITS-1:0] addr;
	} access_t;

	typedef struct packed {
		logic [HITS_W-1:0]  hit_count;
		logic               was_miss;
		logic               was_eviction;
		logic [TOTAL_W-1:0] total_hits;
		logic [TOTAL_W-1:0] total_misses;
		logic [TOTAL_W-1:0] total_evictions;
	} outcome_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	salc_access_if acc_if ();
	salc_result_if res_if ();

	set_assoc_lru_cache_sim u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.access    (acc_if),
		.result    (res_if)
	);

	// behavioural copy of the tag store
	logic                 line_live [0:LINE_COUNT-1];
	logic [ADDR_BITS-1:0] line_tag  [0:LINE_COUNT-1];
	rank_t                line_rank [0:LINE_COUNT-1];
	logic [TOTAL_W-1:0]   exp_hit_total;
	logic [TOTAL_W-1:0]   exp_miss_total;
	logic [TOTAL_W-1:0]   exp_evict_total;
	logic [SBITS_W-1:0]   reg_set_bits;
	logic [BBITS_W-1:0]   reg_block_bits;
	logic [WAYCNT_W-1:0]  reg_ways;

	access_t  access_q [$];
	outcome_t outcomes_q [$];
	access_t  next_access;

	int src_idle_pct;
	int snk_stall_pct;
	int cycle_count;
	int mismatch_count;
	int results_checked;
	int settings_used;
	int fetches_seen;
	int accesses_seen;
	int pred_hits;
	int pred_misses;
	int pred_evictions;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int set_field_bits();
		return (reg_set_bits > SET_W) ? SET_W : int'(reg_set_bits);
	endfunction

	function automatic int ways_used();
		if (reg_ways == '0)
			return 1;
		if (reg_ways > MAX_WAYS)
			return MAX_WAYS;
		return int'(reg_ways);
	endfunction

	function automatic logic [TOTAL_W-1:0] add_sat(input logic [TOTAL_W-1:0] total,
			input int inc);
		if (64'(total) + 64'(inc) > 64'hFFFF_FFFF)
			return '1;
		return total + TOTAL_W'(inc);
	endfunction

	// ages the lines of the set that ranked below 'limit', then makes 'way' newest
	function automatic void promote_way(input int base, input int nways, input int way,
			input int limit);
		for (int i = 0; i < nways; i++)
			if (i != way && line_live[base+i] && int'(line_rank[base+i]) < limit &&
					line_rank[base+i] < RANK_MAX)
				line_rank[base+i] = line_rank[base+i] + 1'b1;
		line_rank[base+way] = '0;
	endfunction

	function automatic outcome_t cache_lookup(input logic [KIND_W-1:0] kind,
			input logic [ADDR_BITS-1:0] addr);
		outcome_t             res;
		int                   sb;
		int                   nways;
		int                   base;
		int                   hit_way;
		int                   free_way;
		int                   victim;
		logic [ADDR_BITS-1:0] line_no;
		logic [ADDR_BITS-1:0] tag;
		res = '0;
		if (kind == KIND_IFETCH) begin
			fetches_seen++;
		end else begin
			accesses_seen++;
			sb       = set_field_bits();
			nways    = ways_used();
			line_no  = addr >> reg_block_bits;
			tag      = line_no >> sb;
			base     = int'(line_no & ((64'd1 << sb) - 1)) * MAX_WAYS;
			hit_way  = -1;
			free_way = -1;
			for (int w = 0; w < nways; w++) begin
				if (line_live[base+w]) begin
					if (hit_way < 0 && line_tag[base+w] == tag)
						hit_way = w;
				end else if (free_way < 0) begin
					free_way = w;
				end
			end
			if (hit_way >= 0) begin
				res.hit_count = HITS_W'(1);
				pred_hits++;
				promote_way(base, nways, hit_way, int'(line_rank[base+hit_way]));
			end else if (free_way >= 0) begin
				res.was_miss = 1'b1;
				line_live[base+free_way] = 1'b1;
				line_tag[base+free_way]  = tag;
				promote_way(base, nways, free_way, MAX_WAYS + 1);
			end else begin
				// oldest rank goes; the lowest way wins a tie
				victim = 0;
				for (int w = 1; w < nways; w++)
					if (line_rank[base+w] > line_rank[base+victim])
						victim = w;
				res.was_miss     = 1'b1;
				res.was_eviction = 1'b1;
				line_tag[base+victim] = tag;
				promote_way(base, nways, victim, int'(line_rank[base+victim]));
			end
			if (kind == KIND_MODIFY)
				res.hit_count = res.hit_count + 1'b1;
			if (res.was_miss)
				pred_misses++;
			if (res.was_eviction)
				pred_evictions++;
			exp_hit_total = add_sat(exp_hit_total, int'(res.hit_count));
			if (res.was_miss)
				exp_miss_total = add_sat(exp_miss_total, 1);
			if (res.was_eviction)
				exp_evict_total = add_sat(exp_evict_total, 1);
		end
		res.total_hits      = exp_hit_total;
		res.total_misses    = exp_miss_total;
		res.total_evictions = exp_evict_total;
		return res;
	endfunction

	// builds an address for the current geometry from tag, set and offset
	function automatic logic [ADDR_BITS-1:0] make_addr(input logic [ADDR_BITS-1:0] tag,
			input int set_no, input logic [ADDR_BITS-1:0] offset);
		logic [ADDR_BITS-1:0] line_no;
		line_no = (tag << set_field_bits()) | ADDR_BITS'(set_no);
		return (line_no << reg_block_bits) | (offset & ((64'd1 << reg_block_bits) - 1));
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at result %0d: %s", results_checked, msg);
	endtask

	task automatic check_outcome();
		outcome_t want;
		if (outcomes_q.size() == 0) begin
			report_mismatch("result with no access outstanding");
		end else begin
			want = outcomes_q.pop_front();
			if (res_if.hit_count !== want.hit_count)
				report_mismatch($sformatf("hit_count %0d, expected %0d",
					res_if.hit_count, want.hit_count));
			if (res_if.was_miss !== want.was_miss)
				report_mismatch($sformatf("was_miss %0b, expected %0b",
					res_if.was_miss, want.was_miss));
			if (res_if.was_eviction !== want.was_eviction)
				report_mismatch($sformatf("was_eviction %0b, expected %0b",
					res_if.was_eviction, want.was_eviction));
			if (res_if.total_hits !== want.total_hits)
				report_mismatch($sformatf("total_hits %0d, expected %0d",
					res_if.total_hits, want.total_hits));
			if (res_if.total_misses !== want.total_misses)
				report_mismatch($sformatf("total_misses %0d, expected %0d",
					res_if.total_misses, want.total_misses));
			if (res_if.total_evictions !== want.total_evictions)
				report_mismatch($sformatf("total_evictions %0d, expected %0d",
					res_if.total_evictions, want.total_evictions));
		end
	endtask

	// access driver: prediction is taken at the edge that accepts the item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_if.valid       <= 1'b0;
			acc_if.access_kind <= KIND_IFETCH;
			acc_if.address     <= '0;
		end else begin
			if (acc_if.valid && acc_if.ready)
				outcomes_q.push_back(cache_lookup(acc_if.access_kind, acc_if.address));
			if (!acc_if.valid || acc_if.ready) begin
				if (access_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_access = access_q.pop_front();
					acc_if.valid       <= 1'b1;
					acc_if.access_kind <= next_access.kind;
					acc_if.address     <= next_access.addr;
				end else begin
					acc_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				results_checked++;
				check_outcome();
			end
			res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			outcomes_q.size());
		$display("FAIL set_assoc_lru_cache_sim");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SET_BITS:   reg_set_bits   = data[SBITS_W-1:0];
			CFG_BLOCK_BITS: reg_block_bits = data[BBITS_W-1:0];
			CFG_WAYS:       reg_ways       = data[WAYCNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_cache(input logic [CFG_DAT_W-1:0] set_val,
			input logic [CFG_DAT_W-1:0] block_val, input logic [CFG_DAT_W-1:0] ways_val);
		write_reg(CFG_SET_BITS, set_val);
		write_reg(CFG_BLOCK_BITS, block_val);
		write_reg(CFG_WAYS, ways_val);
		settings_used++;
	endtask

	task automatic set_idling(input int src_pct, input int snk_pct);
		@(negedge clk);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	// polled on the falling edge so the driver and monitor have settled
	task automatic wait_drained();
		@(negedge clk);
		while (access_q.size() != 0 || acc_if.valid || outcomes_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_access(input logic [KIND_W-1:0] kind,
			input logic [ADDR_BITS-1:0] addr);
		access_t a;
		a.kind = kind;
		a.addr = addr;
		access_q.push_back(a);
	endtask

	// mostly a small tag pool over a few sets so hits and evictions are common
	task automatic queue_random_burst(input int n);
		logic [ADDR_BITS-1:0] tag_pool [0:11];
		logic [KIND_W-1:0]    kind;
		logic [ADDR_BITS-1:0] addr;
		int                   pool_n;
		int                   set_span;
		pool_n = ways_used() + $urandom_range(1, 3);
		for (int k = 0; k < pool_n; k++)
			tag_pool[k] = ($urandom_range(3) == 0) ? {$urandom, $urandom} : ADDR_BITS'(k);
		set_span = 1 << set_field_bits();
		if (set_span > 4 && $urandom_range(1) == 0)
			set_span = 4;
		for (int j = 0; j < n; j++) begin
			case ($urandom_range(9))
				0:       kind = KIND_IFETCH;
				1, 2, 3: kind = KIND_LOAD;
				4, 5, 6: kind = KIND_STORE;
				default: kind = KIND_MODIFY;
			endcase
			if ($urandom_range(99) < 8)
				addr = {$urandom, $urandom};
			else
				addr = make_addr(tag_pool[$urandom_range(pool_n - 1)],
					$urandom_range(set_span - 1), {$urandom, $urandom});
			queue_access(kind, addr);
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_SET_BITS;
		cfg_data           = '0;
		src_idle_pct       = 0;
		snk_stall_pct      = 0;
		mismatch_count     = 0;
		results_checked    = 0;
		settings_used      = 0;
		fetches_seen       = 0;
		accesses_seen      = 0;
		pred_hits          = 0;
		pred_misses        = 0;
		pred_evictions     = 0;
		exp_hit_total      = '0;
		exp_miss_total     = '0;
		exp_evict_total    = '0;
		reg_set_bits       = '0;
		reg_block_bits     = '0;
		reg_ways           = WAYCNT_W'(1);
		for (int i = 0; i < LINE_COUNT; i++) begin
			line_live[i] = 1'b0;
			line_rank[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// four sets, two ways: cold miss, hits, modify, LRU eviction, fetch
		program_cache(5'd2, 5'd4, 5'd2);
		set_idling(0, 0);
		queue_access(KIND_IFETCH, '0);
		queue_access(KIND_LOAD, make_addr(64'd0, 0, 64'd0));
		queue_access(KIND_LOAD, make_addr(64'd0, 0, 64'hF));
		queue_access(KIND_STORE, make_addr(64'd0, 0, 64'h3));
		queue_access(KIND_MODIFY, make_addr(64'd0, 0, 64'd0));
		queue_access(KIND_MODIFY, make_addr(64'd1, 0, 64'd0));
		queue_access(KIND_LOAD, make_addr(64'd2, 0, 64'd0));
		queue_access(KIND_LOAD, make_addr(64'd0, 0, 64'd0));
		queue_access(KIND_LOAD, '1);
		queue_access(KIND_STORE, '1);
		queue_access(KIND_IFETCH, '1);
		wait_drained();

		// set count above the array (clamped) and a zero way count
		program_cache(5'b11111, 5'd0, 5'd0);
		set_idling(0, 0);
		queue_access(KIND_LOAD, 64'h8000_0000_0000_0000);
		queue_access(KIND_MODIFY, 64'h8000_0000_0000_0000);
		queue_access(KIND_LOAD, 64'h40);
		queue_access(KIND_STORE, 64'h8000_0000_0000_0000);
		wait_drained();

		// one set, way count above the maximum, a 16-bit block offset
		program_cache(5'd0, 5'd16, 5'd15);
		set_idling(0, 0);
		for (int k = 0; k < 9; k++)
			queue_access(KIND_LOAD, make_addr(ADDR_BITS'(k), 0, {$urandom, $urandom}));
		queue_access(KIND_MODIFY, make_addr(64'd1, 0, 64'd0));

		// random phases; the tag store is kept across way-count changes
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			case (p)
				0: program_cache(5'd0, 5'd0, 5'd1);
				1: program_cache(5'd6, 5'd16, 5'd8);
				2: program_cache(5'd7, 5'd5, 5'd4);
				3: program_cache(5'd3, 5'd2, 5'd0);
				4: program_cache(5'd2, 5'd6, 5'd15);
				5: program_cache(5'd1, 5'd31, 5'd3);
				default: program_cache(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom_range(16)),
					CFG_DAT_W'($urandom));
			endcase
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(82, 0);
				2: set_idling(0, 82);
				default: set_idling(18, 18);
			endcase
			queue_random_burst(BURST_LEN);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("run covered %0d cache accesses and %0d fetches over %0d geometries",
			accesses_seen, fetches_seen, settings_used);
		$display("predicted %0d hits, %0d misses, %0d evictions; %0d results, %0d mismatches",
			pred_hits, pred_misses, pred_evictions, results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("PASS set_assoc_lru_cache_sim");
		else
			$display("FAIL set_assoc_lru_cache_sim");
		$finish;
	end

endmodule

@@ filelist.f @@
design/salc_pkg.sv
design/salc_access_if.sv
design/salc_result_if.sv
design/salc_ctrl.sv
design/salc_dp.sv
design/set_assoc_lru_cache_sim.sv
bench/set_assoc_lru_cache_sim_tb.sv
